FILE: hw/rtl/ttc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_pkg: thermistor temperature converter shared definitions
// Constants of the beta-equation conversion and the elaboration-time
// functions that build the sample-to-temperature lookup table.
// ----------------------------------------------------------------------------
package ttc_pkg;

	// default converter resolution
	localparam int ADC_BITS_DEF = 12;

	// temperature output limits in 1/16 C
	localparam int T16_MIN = -4371;
	localparam int T16_MAX = 12800;
	localparam int T16_W   = 15;

	// out-of-range thresholds in 1/16 C (-10 C and 120 C)
	localparam int T16_LOW_LIMIT  = -160;
	localparam int T16_HIGH_LIMIT = 1920;

	// gradient segment edges in 1/16 C (15, 30, 45, 60, 75 C)
	localparam int GRAD_E0 = 240;
	localparam int GRAD_E1 = 480;
	localparam int GRAD_E2 = 720;
	localparam int GRAD_E3 = 960;
	localparam int GRAD_E4 = 1200;

	// floor(x / 15) == (x * RECIP15_Q16) >> 16 for x below 3826
	localparam int RECIP15_Q16 = 4370;

	// fixed-point constants of the beta equation
	localparam logic [63:0] LN2_Q30  = 64'd744261118;
	localparam logic [63:0] BT0_Q24  = ((64'd343500 << 24) + 64'd14907) / 64'd29815;
	localparam logic [63:0] KNUM     = 64'd5496000 << 24;
	// Y is in 1/1600 K; saturation bound and offset to the 1/16 C grid
	localparam logic [63:0] Y_SAT    = 64'd1717200;
	localparam logic [63:0] Y_ROUND  = 64'd60;
	localparam logic [63:0] T16_STEP = 64'd100;

	// log2 in Q.24: leading-one index plus 24 fraction bits by squaring
	function automatic logic [63:0] log2_q24(logic [31:0] x);
		logic [4:0]  k;
		logic [63:0] y;
		logic [63:0] frac;
		k    = '0;
		frac = '0;
		for (int j = 1; j < 32; j++) begin
			if ((x >> j) != 32'd0)
				k = j[4:0];
		end
		y = {32'd0, x} << (5'd31 - k);
		for (int i = 23; i >= 0; i--) begin
			y = (y * y) >> 31;
			if (y >= 64'h1_0000_0000) begin
				y       = y >> 1;
				frac[i] = 1'b1;
			end
		end
		return ({59'd0, k} << 24) | frac;
	endfunction

	// restoring long division, unsigned 64 by 64
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [64:0] r;
		logic [63:0] quo;
		r   = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r      = r - {1'b0, d};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// one table entry: ADC sample to temperature in 1/16 C, saturated
	function automatic logic [T16_W-1:0] sample_to_t16(logic [31:0] s, int adc_bits);
		logic [31:0]        m;
		logic [63:0]        la;
		logic [63:0]        lb;
		logic [63:0]        ad;
		logic [63:0]        mag;
		logic signed [63:0] d;
		logic [63:0]        y;
		logic signed [63:0] z;
		m = 32'd1 << adc_bits;
		if (s == 32'd0)
			return T16_W'(T16_MIN);
		la  = log2_q24(s);
		lb  = log2_q24(m - s);
		ad  = (la >= lb) ? (la - lb) : (lb - la);
		mag = (ad * LN2_Q30) >> 30;
		if (la >= lb)
			d = signed'(BT0_Q24) + signed'(mag);
		else
			d = signed'(BT0_Q24) - signed'(mag);
		if (d <= 64'sd0)
			return T16_W'(T16_MIN);
		y = udiv64(KNUM, unsigned'(d));
		if (y > Y_SAT)
			return T16_W'(T16_MAX);
		z = signed'((y + Y_ROUND) / T16_STEP) + 64'(T16_MIN);
		if (z < 64'(T16_MIN))
			return T16_W'(T16_MIN);
		if (z > 64'(T16_MAX))
			return T16_W'(T16_MAX);
		return z[T16_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/thermistor_temp_to_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_temp_to_color: NTC thermistor reading to temperature and color
// Converts a divider sample to 1/16 C by table lookup, flags readings outside
// -10..120 C and derives a brightness-scaled blue-to-red gradient color.
// ----------------------------------------------------------------------------
// The block takes one sample per clock when the output side does not stall.
// Stage one reads a lookup table of 2^ADC_BITS temperatures built at
// elaboration from the beta equation, stage two picks the gradient segment
// and multiplies the brightness by the ramp position, stage three divides by
// the segment width and registers the result. A stalled output holds the
// pipeline; bubbles are squeezed out so a new request is taken whenever some
// stage is free.

module thermistor_temp_to_color
	import ttc_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// brightness register
	input  logic                    cfg_write_en,
	input  logic [7:0]              cfg_write_data,
	// sample channel
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic [ADC_BITS-1:0]     adc_sample,
	// result channel
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [T16_W-1:0] temp_sixteenths,
	output logic                    out_of_range,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue
);

	localparam int ROM_DEPTH = 1 << ADC_BITS;

	typedef enum logic [2:0] {
		SEG_BLUE,
		SEG_GREEN_UP,
		SEG_BLUE_DOWN,
		SEG_RED_UP,
		SEG_GREEN_DOWN,
		SEG_RED
	} seg_t;

	logic [7:0] brightness_q;

	logic                    valid_s1, valid_s2, valid_s3;
	logic                    en_s1, en_s2, en_s3;
	logic signed [T16_W-1:0] temp_s1, temp_s2;
	seg_t                    seg_s2;
	logic                    oor_s2;
	logic [15:0]             prod_s2;

	seg_t                    seg_d;
	logic [T16_W-1:0]        ramp_d;
	logic [24:0]             recip_d;
	logic [7:0]              scaled_d;
	logic [7:0]              red_d, green_d, blue_d;

	logic [T16_W-1:0] temp_rom [ROM_DEPTH];

	// constant temperature table, one entry per sample code
	for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
		localparam logic [T16_W-1:0] ENTRY = sample_to_t16(32'(i), ADC_BITS);
		assign temp_rom[i] = ENTRY;
	end

	// brightness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '0;
		end else if (cfg_write_en) begin
			brightness_q <= cfg_write_data;
		end
	end

	// stage enables: a stage loads when it is empty or its successor moves
	assign en_s3        = !result_stall || !valid_s3;
	assign en_s2        = en_s3 || !valid_s2;
	assign en_s1        = en_s2 || !valid_s1;
	assign sample_stall = !en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= sample_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
		end
	end

	// stage 1: table read
	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid)
			temp_s1 <= signed'(temp_rom[adc_sample]);
	end

	// gradient segment and ramp position
	always_comb begin
		priority if (temp_s1 <= T16_W'(GRAD_E0)) begin
			seg_d  = SEG_BLUE;
			ramp_d = '0;
		end else if (temp_s1 < T16_W'(GRAD_E1)) begin
			seg_d  = SEG_GREEN_UP;
			ramp_d = unsigned'(temp_s1 - T16_W'(GRAD_E0));
		end else if (temp_s1 < T16_W'(GRAD_E2)) begin
			seg_d  = SEG_BLUE_DOWN;
			ramp_d = unsigned'(T16_W'(GRAD_E2) - temp_s1);
		end else if (temp_s1 < T16_W'(GRAD_E3)) begin
			seg_d  = SEG_RED_UP;
			ramp_d = unsigned'(temp_s1 - T16_W'(GRAD_E2));
		end else if (temp_s1 < T16_W'(GRAD_E4)) begin
			seg_d  = SEG_GREEN_DOWN;
			ramp_d = unsigned'(T16_W'(GRAD_E4) - temp_s1);
		end else begin
			seg_d  = SEG_RED;
			ramp_d = '0;
		end
	end

	// stage 2: segment, range flag, brightness times ramp
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			temp_s2 <= temp_s1;
			seg_s2  <= seg_d;
			oor_s2  <= (temp_s1 < T16_W'(T16_LOW_LIMIT)) ||
			           (temp_s1 > T16_W'(T16_HIGH_LIMIT));
			prod_s2 <= 16'(brightness_q) * 16'(ramp_d[7:0]);
		end
	end

	// divide by 240: divide by 16 with a shift by 4, then reciprocal of 15
	assign recip_d  = 25'(prod_s2[15:4]) * 25'(RECIP15_Q16);
	assign scaled_d = recip_d[23:16];

	// channel select
	always_comb begin
		red_d   = '0;
		green_d = '0;
		blue_d  = '0;
		unique case (seg_s2)
			SEG_BLUE: begin
				blue_d = brightness_q;
			end
			SEG_GREEN_UP: begin
				green_d = scaled_d;
				blue_d  = brightness_q;
			end
			SEG_BLUE_DOWN: begin
				green_d = brightness_q;
				blue_d  = scaled_d;
			end
			SEG_RED_UP: begin
				red_d   = scaled_d;
				green_d = brightness_q;
			end
			SEG_GREEN_DOWN: begin
				red_d   = brightness_q;
				green_d = scaled_d;
			end
			SEG_RED: begin
				red_d = brightness_q;
			end
			default: begin
				red_d = '0;
			end
		endcase
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			temp_sixteenths <= temp_s2;
			out_of_range    <= oor_s2;
			red             <= red_d;
			green           <= green_d;
			blue            <= blue_d;
		end
	end

	assign result_valid = valid_s3;

endmodule

FILE: dv/tb_thermistor_temp_to_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermistor_temp_to_color: self-checking bench for the thermistor reader
// Sends ADC samples under random valid/stall pressure at several brightness
// levels. Every reading that comes out is compared as a whole with a bit-exact
// fixed-point beta-equation and gradient calculation done here or a table value.
// ----------------------------------------------------------------------------

module tb_thermistor_temp_to_color;
	import ttc_pkg::*;

	localparam int SAMPLE_W    = ADC_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;
	localparam int SEG_SPAN    = GRAD_E1 - GRAD_E0;

	// beta-equation constants in fixed point (ln 2 in Q30, B/T0 in Q24)
	localparam logic [63:0] LN2_FRAC     = 64'd744261118;
	localparam logic [63:0] BETA_OVER_T0 = ((64'd343500 << 24) + 64'd14907) / 64'd29815;
	localparam logic [63:0] KELVIN_NUMER = 64'd5496000 << 24;
	localparam logic [63:0] KELVIN_SAT   = 64'd1717200;

	typedef struct packed {
		logic signed [T16_W-1:0] temp;
		logic                    oor;
		logic [7:0]              red;
		logic [7:0]              green;
		logic [7:0]              blue;
	} color_reading_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [7:0]          level;
		logic                typed;
		color_reading_t      want;
	} probe_row_t;

	logic                    clk             = 1'b0;
	logic                    arst_n          = 1'b0;
	logic                    cfg_write_en    = 1'b0;
	logic [7:0]              cfg_write_data  = 8'd0;
	logic                    sample_valid    = 1'b0;
	logic                    sample_stall;
	logic [SAMPLE_W-1:0]     adc_sample      = '0;
	logic                    result_valid;
	logic                    result_stall    = 1'b0;
	logic signed [T16_W-1:0] temp_sixteenths;
	logic                    out_of_range;
	logic [7:0]              red;
	logic [7:0]              green;
	logic [7:0]              blue;

	color_reading_t pending_readings[$];
	color_reading_t next_reading     = '0;
	logic [7:0]     bright_cfg       = 8'd0;
	int             send_idle_pct    = 0;
	int             recv_stall_pct   = 0;
	int             mismatch_count   = 0;
	int             cycle_count      = 0;

	// directed probes: extremes, segment edges, alarm thresholds, bit patterns
	probe_row_t directed_rows [0:23] = '{
		'{12'd0,    8'd0,   1'b1, '{T16_W'(T16_MIN), 1'b1, 8'd0, 8'd0, 8'd0}},
		'{12'd4095, 8'd0,   1'b0, '0},
		'{12'd2048, 8'd0,   1'b0, '0},
		'{12'd1,    8'd0,   1'b0, '0},
		'{12'd0,    8'd255, 1'b1, '{T16_W'(T16_MIN), 1'b1, 8'd0, 8'd0, 8'd255}},
		'{12'd1,    8'd255, 1'b0, '0},
		'{12'd4095, 8'd255, 1'b0, '0},
		'{12'd3370, 8'd255, 1'b0, '0},
		'{12'd3380, 8'd255, 1'b0, '0},
		'{12'd239,  8'd255, 1'b0, '0},
		'{12'd240,  8'd255, 1'b0, '0},
		'{12'd2451, 8'd255, 1'b0, '0},
		'{12'd1854, 8'd255, 1'b0, '0},
		'{12'd1338, 8'd255, 1'b0, '0},
		'{12'd940,  8'd255, 1'b0, '0},
		'{12'd657,  8'd255, 1'b0, '0},
		'{12'd2048, 8'd255, 1'b0, '0},
		'{12'hAAA,  8'd255, 1'b0, '0},
		'{12'h555,  8'd255, 1'b0, '0},
		'{12'd0,    8'd1,   1'b1, '{T16_W'(T16_MIN), 1'b1, 8'd0, 8'd0, 8'd1}},
		'{12'd1500, 8'd1,   1'b0, '0},
		'{12'd800,  8'd1,   1'b0, '0},
		'{12'd2200, 8'd128, 1'b0, '0},
		'{12'd1100, 8'd128, 1'b0, '0}
	};

	thermistor_temp_to_color uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.adc_sample      (adc_sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.temp_sixteenths (temp_sixteenths),
		.out_of_range    (out_of_range),
		.red             (red),
		.green           (green),
		.blue            (blue)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// log2 in Q.24: leading-one position, then 24 fraction bits by squaring
	function automatic logic [63:0] log2_fix(input logic [31:0] x);
		int unsigned lead;
		logic [63:0] mant;
		logic [63:0] frac;
		lead = 0;
		frac = '0;
		for (int j = 1; j < 32; j++) begin
			if (x[j])
				lead = j;
		end
		mant = {32'd0, x} << (31 - lead);
		for (int i = 23; i >= 0; i--) begin
			mant = (mant * mant) >> 31;
			if (mant >= 64'h1_0000_0000) begin
				mant    = mant >> 1;
				frac[i] = 1'b1;
			end
		end
		return (64'(lead) << 24) | frac;
	endfunction

	// sample to temperature in 1/16 C, saturated at both ends
	function automatic int sixteenths_of_sample(input logic [SAMPLE_W-1:0] s);
		logic [63:0] la;
		logic [63:0] lb;
		logic [63:0] diff;
		logic [63:0] mag;
		logic [63:0] kel;
		longint      denom;
		longint      t;
		if (s == '0)
			return T16_MIN;
		la   = log2_fix(32'(s));
		lb   = log2_fix((32'd1 << SAMPLE_W) - 32'(s));
		diff = (la >= lb) ? (la - lb) : (lb - la);
		mag  = (diff * LN2_FRAC) >> 30;
		if (la >= lb)
			denom = $signed(BETA_OVER_T0) + $signed(mag);
		else
			denom = $signed(BETA_OVER_T0) - $signed(mag);
		if (denom <= 0)
			return T16_MIN;
		kel = KELVIN_NUMER / 64'(denom);
		if (kel > KELVIN_SAT)
			return T16_MAX;
		t = ($signed(kel) + 60) / 100 + T16_MIN;
		if (t < T16_MIN)
			return T16_MIN;
		if (t > T16_MAX)
			return T16_MAX;
		return int'(t);
	endfunction

	// full reading: temperature, alarm flag and gradient color
	function automatic color_reading_t reading_for_sample(input logic [SAMPLE_W-1:0] s,
			input logic [7:0] level);
		color_reading_t res;
		int q;
		int b;
		q = sixteenths_of_sample(s);
		b = int'(level);
		res = '0;
		res.temp = q[T16_W-1:0];
		res.oor  = (q < T16_LOW_LIMIT) || (q > T16_HIGH_LIMIT);
		if (q <= GRAD_E0) begin
			res.blue = level;
		end else if (q < GRAD_E1) begin
			res.green = 8'((b * (q - GRAD_E0)) / SEG_SPAN);
			res.blue  = level;
		end else if (q < GRAD_E2) begin
			res.green = level;
			res.blue  = 8'((b * (GRAD_E2 - q)) / SEG_SPAN);
		end else if (q < GRAD_E3) begin
			res.red   = 8'((b * (q - GRAD_E2)) / SEG_SPAN);
			res.green = level;
		end else if (q < GRAD_E4) begin
			res.red   = level;
			res.green = 8'((b * (GRAD_E4 - q)) / SEG_SPAN);
		end else begin
			res.red = level;
		end
		return res;
	endfunction

	// gradient window as often as uniform, some near the rails
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
		if (roll < 90)
			return SAMPLE_W'($urandom_range(560, 2600));
		if (roll < 95)
			return SAMPLE_W'($urandom_range(0, 15));
		return SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 16, (1 << SAMPLE_W) - 1));
	endfunction

	task automatic note_mismatch(input string what, input color_reading_t want,
			input color_reading_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: want temp %0d oor %0b rgb %0d,%0d,%0d got temp %0d oor %0b rgb %0d,%0d,%0d",
				$realtime, what, want.temp, want.oor, want.red, want.green, want.blue,
				got.temp, got.oor, got.red, got.green, got.blue);
	endtask

	// one request; entered and left at a falling edge
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
			input color_reading_t typed_want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		next_reading = typed ? typed_want : reading_for_sample(s, bright_cfg);
		adc_sample   <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// brightness write once every outstanding reading is back
	task automatic set_brightness(input logic [7:0] level);
		sample_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= level;
		bright_cfg     = level;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// output side stalls at random
	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	// log accepted requests, check readings, watch the cycle budget
	always @(posedge clk) begin
		color_reading_t got;
		color_reading_t want;
		got = {temp_sixteenths, out_of_range, red, green, blue};
		cycle_count++;
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				pending_readings.push_back(next_reading);
			if (result_valid && !result_stall) begin
				if (pending_readings.size() == 0) begin
					note_mismatch("unexpected reading", '0, got);
				end else begin
					want = pending_readings.pop_front();
					if (got !== want)
						note_mismatch("reading mismatch", want, got);
				end
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL thermistor_temp_to_color");
			$finish;
		end
	end

	initial begin
		logic [7:0] level;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed probes; first rows run on the reset brightness
		send_idle_pct  = 11;
		recv_stall_pct = 71;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].level != bright_cfg)
				set_brightness(directed_rows[i].level);
			send_sample(directed_rows[i].sample, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// random phases: receiver stalls, then sender idles, then no gaps
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 0) begin
				send_idle_pct  = 11;
				recv_stall_pct = 71;
			end else if (phase == 1) begin
				send_idle_pct  = 71;
				recv_stall_pct = 11;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			for (int blk = 0; blk < 4; blk++) begin
				case (phase * 4 + blk)
					0: level = 8'd255;
					1: level = 8'd0;
					2: level = 8'd1;
					3: level = 8'd128;
					default: level = 8'($urandom_range(0, 255));
				endcase
				set_brightness(level);
				repeat (105)
					send_sample(pick_sample(), 1'b0, '0);
			end
		end

		// drain, then let the pipeline settle
		sample_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatch_count == 0)
			$display("PASS thermistor_temp_to_color");
		else
			$display("FAIL thermistor_temp_to_color");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ttc_pkg.sv
hw/rtl/thermistor_temp_to_color.sv
dv/tb_thermistor_temp_to_color.sv
